>>> rtl/core/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// text_console_writer_macros.svh
// Assertion shorthands for the text console writer, clocked on clk_i and
// held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Check cons in the same cycle as ante.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, character codes, command and status types for the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Grid geometry
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_STOP      = 8;
  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CELL_W = $clog2(CELL_COUNT);

  // Port field widths
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int POS_W       = 11;
  localparam int CELL_DATA_W = ATTR_W + CHAR_W;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PROMPT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LAST      = 8'h7F;

  localparam logic [ATTR_W-1:0]      RESET_ATTR  = 8'h0F;
  localparam logic [CELL_DATA_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Tab stop lookup: next column and a wrap flag, indexed by current column
  typedef logic [COLUMNS-1:0][COL_W:0] tab_table_t;

  function automatic tab_table_t build_tab_table();
    tab_table_t t;
    int         stop;
    t = '0;
    for (int i = 0; i < COLUMNS; i++) begin
      stop = (i / TAB_STOP + 1) * TAB_STOP;
      if (stop >= COLUMNS) begin
        t[i] = {1'b1, {COL_W{1'b0}}};
      end else begin
        t[i] = {1'b0, COL_W'(stop)};
      end
    end
    return t;
  endfunction

  localparam tab_table_t TAB_TABLE = build_tab_table();

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_PROMPT,
    ST_FILL,
    ST_RESP
  } ctrl_state_e;

  typedef enum logic [2:0] {
    COL_HOLD,
    COL_INC,
    COL_DEC,
    COL_TAB,
    COL_ZERO,
    COL_ONE
  } col_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_BLANK_PREV,
    WR_PROMPT,
    WR_SCROLL,
    WR_FILL,
    WR_INIT
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_INDEX,
    RD_SCROLL_FIRST,
    RD_SCROLL_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    row_adv;
    logic    row_clr;
    col_op_e col_op;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    data_cap;
  } dp_cmd_t;

  typedef struct packed {
    logic op_put;
    logic op_clear;
    logic op_read;
    logic ch_print;
    logic ch_bs;
    logic ch_tab;
    logic ch_nl;
    logic ch_ret;
    logic read_ok;
    logic col_zero;
    logic col_last;
    logic tab_wrap;
    logic last_row;
    logic cnt_last;
  } dp_stat_t;

endpackage

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: walks the clearing pass, decodes
// each transaction and steps scroll, fill and prompt sequences.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        prompt_q, prompt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      prompt_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      prompt_q <= prompt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    prompt_d = prompt_q;
    cmd_o    = '{load: 1'b0, row_adv: 1'b0, row_clr: 1'b0, col_op: COL_HOLD,
                 wr_sel: WR_NONE, rd_sel: RD_NONE, cnt_clr: 1'b0, cnt_inc: 1'b0,
                 data_cap: 1'b0};
    busy     = (state_q != ST_IDLE);
    done_o   = (state_q == ST_RESP);

    unique case (state_q)
      ST_INIT: begin
        cmd_o.wr_sel  = WR_INIT;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d  = ST_RESP;
        prompt_d = 1'b0;
        if (stat_i.op_put) begin
          if (stat_i.ch_print) begin
            cmd_o.wr_sel = WR_CHAR;
            cmd_o.col_op = COL_INC;
            if (stat_i.col_last && stat_i.last_row) begin
              cmd_o.rd_sel  = RD_SCROLL_FIRST;
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_SCROLL;
            end
          end else if (stat_i.ch_bs) begin
            if (!stat_i.col_zero) begin
              cmd_o.wr_sel = WR_BLANK_PREV;
              cmd_o.col_op = COL_DEC;
            end
          end else if (stat_i.ch_tab) begin
            if (!stat_i.col_zero) begin
              cmd_o.col_op = COL_TAB;
              if (stat_i.tab_wrap && stat_i.last_row) begin
                cmd_o.rd_sel  = RD_SCROLL_FIRST;
                cmd_o.cnt_clr = 1'b1;
                state_d       = ST_SCROLL;
              end
            end
          end else if (stat_i.ch_nl || stat_i.ch_ret) begin
            cmd_o.col_op  = COL_ZERO;
            cmd_o.row_adv = 1'b1;
            if (stat_i.last_row) begin
              cmd_o.rd_sel  = RD_SCROLL_FIRST;
              cmd_o.cnt_clr = 1'b1;
              prompt_d      = stat_i.ch_ret;
              state_d       = ST_SCROLL;
            end else if (stat_i.ch_ret) begin
              state_d = ST_PROMPT;
            end
          end
        end else if (stat_i.op_clear) begin
          cmd_o.col_op  = COL_ZERO;
          cmd_o.row_clr = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_FILL;
        end else if (stat_i.op_read) begin
          if (stat_i.read_ok) begin
            cmd_o.rd_sel = RD_INDEX;
            state_d      = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.data_cap = 1'b1;
        state_d        = ST_RESP;
      end
      ST_SCROLL: begin
        cmd_o.wr_sel  = WR_SCROLL;
        cmd_o.rd_sel  = RD_SCROLL_NEXT;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = prompt_q ? ST_PROMPT : ST_RESP;
        end
      end
      ST_PROMPT: begin
        cmd_o.wr_sel = WR_PROMPT;
        cmd_o.col_op = COL_ONE;
        state_d      = ST_RESP;
      end
      ST_FILL: begin
        cmd_o.wr_sel  = WR_FILL;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.cnt_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, attribute and sweep counter registers, the screen memory and its
// address and data selection.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [POS_W-1:0]       cell_index_i,
  input  logic                   cfg_we_i,
  input  logic [ATTR_W-1:0]      cfg_attr_i,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CELL_DATA_W-1:0] cell_data_o
);

  // Latched transaction
  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [POS_W-1:0]  idx_q;

  logic [COL_W-1:0]       col_q, col_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [CELL_W-1:0]      cnt_q;
  logic [ATTR_W-1:0]      attr_q;
  logic [CELL_DATA_W-1:0] data_q;

  logic [CELL_W-1:0]      row_base, pos;
  logic [CELL_W:0]        next_cnt;
  logic [COL_W:0]         tab_ent;
  logic                   wrap;
  logic [CELL_DATA_W-1:0] blank;

  logic                   we, re;
  logic [CELL_W-1:0]      waddr, raddr;
  logic [CELL_DATA_W-1:0] wdata, rdata;

  assign row_base = CELL_W'(32'(row_q) * COLUMNS);
  assign pos      = row_base + CELL_W'(col_q);
  assign next_cnt = {1'b0, cnt_q} + (CELL_W + 1)'(1);
  assign tab_ent  = TAB_TABLE[col_q];
  assign blank    = {attr_q, CH_SPACE};

  always_comb begin
    stat_o.op_put   = (op_q == OP_PUT);
    stat_o.op_clear = (op_q == OP_CLEAR);
    stat_o.op_read  = (op_q == OP_READ);
    stat_o.ch_print = (ch_q >= CH_SPACE) && (ch_q <= CH_LAST);
    stat_o.ch_bs    = (ch_q == CH_BACKSPACE);
    stat_o.ch_tab   = (ch_q == CH_TAB);
    stat_o.ch_nl    = (ch_q == CH_NEWLINE);
    stat_o.ch_ret   = (ch_q == CH_RETURN);
    stat_o.read_ok  = (32'(idx_q) < CELL_COUNT);
    stat_o.col_zero = (col_q == '0);
    stat_o.col_last = (col_q == COL_W'(COLUMNS - 1));
    stat_o.tab_wrap = tab_ent[COL_W];
    stat_o.last_row = (row_q == ROW_W'(ROWS - 1));
    stat_o.cnt_last = (cnt_q == CELL_W'(CELL_COUNT - 1));
  end

  // Cursor next state; a wrap or line feed on the last row holds the row
  // and leaves the scroll to the sweep
  always_comb begin
    col_d = col_q;
    wrap  = 1'b0;
    case (cmd_i.col_op)
      COL_INC: begin
        wrap  = stat_o.col_last;
        col_d = stat_o.col_last ? '0 : col_q + COL_W'(1);
      end
      COL_DEC:  col_d = col_q - COL_W'(1);
      COL_TAB: begin
        wrap  = tab_ent[COL_W];
        col_d = tab_ent[COL_W-1:0];
      end
      COL_ZERO: col_d = '0;
      COL_ONE:  col_d = COL_W'(1);
      default:  col_d = col_q;
    endcase

    row_d = row_q;
    if (cmd_i.row_clr) begin
      row_d = '0;
    end else if ((wrap || cmd_i.row_adv) && !stat_o.last_row) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  // Memory write port
  always_comb begin
    we    = 1'b1;
    waddr = cnt_q;
    wdata = blank;
    unique case (cmd_i.wr_sel)
      WR_CHAR: begin
        waddr = pos;
        wdata = {attr_q, ch_q};
      end
      WR_BLANK_PREV: waddr = pos - CELL_W'(1);
      WR_PROMPT: begin
        waddr = row_base;
        wdata = {attr_q, CH_PROMPT};
      end
      WR_SCROLL: wdata = (32'(cnt_q) < LAST_ROW_BASE) ? rdata : blank;
      WR_FILL:   wdata = blank;
      WR_INIT:   wdata = RESET_BLANK;
      default:   we = 1'b0;
    endcase
  end

  // Memory read port; scroll reads run one row ahead of the writes
  always_comb begin
    re    = 1'b0;
    raddr = CELL_W'(idx_q);
    unique case (cmd_i.rd_sel)
      RD_INDEX:        re = 1'b1;
      RD_SCROLL_FIRST: begin
        re    = 1'b1;
        raddr = CELL_W'(COLUMNS);
      end
      RD_SCROLL_NEXT: begin
        re    = (32'(next_cnt) < LAST_ROW_BASE);
        raddr = CELL_W'(next_cnt + (CELL_W + 1)'(COLUMNS));
      end
      default: re = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_DATA_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      attr_q <= RESET_ATTR;
      data_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CELL_W'(1);
      end
      if (cfg_we_i) begin
        attr_q <= cfg_attr_i;
      end
      if (cmd_i.load) begin
        data_q <= '0;
      end else if (cmd_i.data_cap) begin
        data_q <= rdata;
      end
    end
  end

  assign cursor_position_o = POS_W'(pos);
  assign cell_data_o       = data_q;

endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: 80x25 grid of attribute/character cells with a cursor,
// put, clear and read transactions.
// ----------------------------------------------------------------------------
// Sequence: a put, backspace, tab, newline or out-of-range read goes from
//   decode straight to the result strobe; an in-range read or a prompt
//   return first passes the read or prompt state. A scroll or a clear
//   sweeps every cell once, one cell a cycle through the single write port
//   of the screen RAM. A new transaction is taken only while busy is low;
//   busy stays high until the result strobe ends; the receiver cannot stall.
// Reset: blanks all 2000 cells with 0x0F20, one a cycle, with busy high.
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Transaction request
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [CHAR_W-1:0]      char_code_i,
  input  logic [POS_W-1:0]       cell_index_i,
  // Result strobe
  output logic                   done_o,
  output logic [POS_W-1:0]       cursor_position_o,
  output logic [CELL_DATA_W-1:0] cell_data_o,
  // Attribute register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ATTR_W-1:0]      cfg_text_attribute_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The attribute register takes a write in any cycle, even during the
  // clearing pass; the reset pass uses its own fixed blank.
  assign cfg_ready_o = 1'b1;

  // Sequencer: decode the latched transaction and drive the datapath
  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath: cursor, screen RAM, sweep counter and result register
  tcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_attr_i        (cfg_text_attribute_i),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o)
  );

  // A result always returns the block to idle in the next cycle
  `TCW_ASSERT_NEXT(a_done_then_idle, done_o, !busy, "result not followed by idle")

  // The cursor never leaves the grid
  `TCW_ASSERT_SAME(a_cursor_in_grid, 1'b1, 32'(cursor_position_o) < CELL_COUNT,
                   "cursor outside the grid")

  // Only a read transaction returns cell data
  `TCW_ASSERT_SAME(a_data_only_on_read, done_o && !stat.op_read, cell_data_o == '0,
                   "cell data on a non-read transaction")

endmodule
